>>> hw/rtl/lrg_pkg.sv
// Shared types, constants and the sine table for the LED ring falloff block.
// Used by every module of the block; depends on nothing.
package lrg_pkg;

	// Default ring size and fixed field widths.
	localparam int unsigned RING_LEDS_DEF = 12;
	localparam int unsigned IDX_W         = 5;   // holds an LED index for rings of up to 32
	localparam int unsigned CIDX_W        = 4;
	localparam int unsigned ANGLE_W       = 13;
	localparam int unsigned COLOR_W       = 24;
	localparam int unsigned CH_W          = 8;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned IN_DATA_W     = 24;
	localparam int unsigned OUT_DATA_W    = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR       = 3'd4;

	// Mode register values.
	localparam logic MODE_SINGLE   = 1'b0;
	localparam logic MODE_GRADIENT = 1'b1;

	// Configuration as seen by the pixel engine.
	typedef struct packed {
		logic               mode;
		logic [COLOR_W-1:0] start_color;
		logic [COLOR_W-1:0] end_color;
		logic [CH_W-1:0]    peak_brightness;
		logic [CH_W-1:0]    floor_brightness;
	} cfg_t;

	// One classified item: the first LED of its run and the pointer angle.
	typedef struct packed {
		logic [IDX_W-1:0]   start_idx;
		logic [ANGLE_W-1:0] angle;
	} item_t;

	// Unsigned Q1.15 sine at every 5 degrees; index 18 is 90 degrees.
	function automatic logic [15:0] sine_q15(input logic [IDX_W-1:0] seg);
		logic [15:0] v;
		case (seg)
			5'd0:    v = 16'd0;
			5'd1:    v = 16'd2856;
			5'd2:    v = 16'd5690;
			5'd3:    v = 16'd8481;
			5'd4:    v = 16'd11207;
			5'd5:    v = 16'd13848;
			5'd6:    v = 16'd16384;
			5'd7:    v = 16'd18795;
			5'd8:    v = 16'd21063;
			5'd9:    v = 16'd23170;
			5'd10:   v = 16'd25102;
			5'd11:   v = 16'd26842;
			5'd12:   v = 16'd28378;
			5'd13:   v = 16'd29698;
			5'd14:   v = 16'd30792;
			5'd15:   v = 16'd31651;
			5'd16:   v = 16'd32270;
			5'd17:   v = 16'd32643;
			default: v = 16'd32768;
		endcase
		return v;
	endfunction

	// One 8-bit channel of a packed RGB color, red first.
	function automatic logic [CH_W-1:0] color_chan(input logic [COLOR_W-1:0] c, input int ch);
		return c[CH_W*(2-ch) +: CH_W];
	endfunction

endpackage

>>> hw/rtl/led_ring_angular_falloff_gradient.sv
// LED ring falloff block, top level: configuration registers, the input
// front, the item queue and the pixel engine. Depends on lrg_pkg.
//
// For each accepted item (center LED and pointer angle in 1/16 degree) the
// block sends RING_LEDS pixels, starting (RING_LEDS-1)/2 LEDs before the
// center and going around the ring, one per cycle unless m_tready stalls
// the output, with tlast on the final pixel. The pixel sequencer issues the
// LEDs in order; runs follow each other with no gap while items wait in the
// two-entry queue. With the engine idle, an accepted item passes through the
// queue, the sequencer, pipeline stages 2 to 12 and the output register. Each
// pixel's brightness follows one minus the sine of half the angle to the LED,
// between the floor and peak registers, and scales either the start color or
// a gradient toward the end color.
// Configuration is written with cfg_we, cfg_index and cfg_data; the user must write it only while idle (not enforced).
module led_ring_angular_falloff_gradient #(
	parameter int unsigned RING_LEDS = lrg_pkg::RING_LEDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lrg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lrg_pkg::COLOR_W-1:0]      cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0: center_index[3:0], pointer_angle[16:4], zero fill.
	input  logic [lrg_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Fields from bit 0: pixel_index[3:0], red[11:4], green[19:12], blue[27:20], zero fill.
	output logic [lrg_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast
);

	lrg_pkg::cfg_t  cfg_q;
	logic           q_full;
	logic           push;
	lrg_pkg::item_t push_item;
	logic           q_pop;
	logic           q_valid;
	lrg_pkg::item_t q_item;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode             <= lrg_pkg::MODE_GRADIENT;
			cfg_q.start_color      <= 24'hFF0000;
			cfg_q.end_color        <= 24'h0000FF;
			cfg_q.peak_brightness  <= 8'd255;
			cfg_q.floor_brightness <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrg_pkg::REG_MODE:        cfg_q.mode             <= cfg_data[0];
				lrg_pkg::REG_START_COLOR: cfg_q.start_color      <= cfg_data;
				lrg_pkg::REG_END_COLOR:   cfg_q.end_color        <= cfg_data;
				lrg_pkg::REG_PEAK:        cfg_q.peak_brightness  <= cfg_data[7:0];
				lrg_pkg::REG_FLOOR:       cfg_q.floor_brightness <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	lrg_front #(.RING_LEDS(RING_LEDS)) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	lrg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.rd_valid  (q_valid),
		.rd_item   (q_item)
	);

	lrg_back #(.RING_LEDS(RING_LEDS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> hw/rtl/lrg_front.sv
// Input side of the LED ring falloff block: accepts items and classifies them.
// Depends on lrg_pkg; feeds lrg_queue.
module lrg_front #(
	parameter int unsigned RING_LEDS = lrg_pkg::RING_LEDS_DEF
) (
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0: center_index[3:0], pointer_angle[16:4], zero fill.
	input  logic [lrg_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                             q_full,
	output logic                             push,
	output lrg_pkg::item_t                   push_item
);

	localparam int unsigned LEFT = (RING_LEDS - 1) / 2;

	logic [lrg_pkg::IDX_W-1:0] center;
	logic [lrg_pkg::IDX_W+1:0] start_sum;

	// Reduce the center index into the ring; it is below 16, so five steps suffice for rings of three LEDs or more.
	always_comb begin
		center = {1'b0, s_tdata[lrg_pkg::CIDX_W-1:0]};
		for (int i = 0; i < 5; i++) begin
			if ({1'b0, center} >= 6'(RING_LEDS)) begin
				center = 5'(6'(center) - 6'(RING_LEDS));
			end
		end
	end

	// The run starts LEFT LEDs before the center, wrapped around the ring.
	always_comb begin
		start_sum = 7'(center) + 7'(RING_LEDS - LEFT);
		if (start_sum >= 7'(RING_LEDS)) begin
			start_sum = start_sum - 7'(RING_LEDS);
		end
	end

	assign s_tready            = !q_full;
	assign push                = s_tvalid && !q_full;
	assign push_item.start_idx = start_sum[lrg_pkg::IDX_W-1:0];
	assign push_item.angle     = s_tdata[lrg_pkg::CIDX_W +: lrg_pkg::ANGLE_W];

endmodule

>>> hw/rtl/lrg_queue.sv
// Two-entry queue that separates item acceptance from pixel generation.
// Depends on lrg_pkg for the item type.
module lrg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lrg_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           rd_valid,
	output lrg_pkg::item_t rd_item
);

	lrg_pkg::item_t entry_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	logic do_push;
	logic do_pop;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = entry_q[rp_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wp_q] <= push_item;
		end
	end

endmodule

>>> hw/rtl/lrg_back.sv
// Pixel engine: steps through the LEDs of each queued item and computes the
// falloff brightness and scaled color of each in a stalling pipeline.
// Depends on lrg_pkg; takes items from lrg_queue.
module lrg_back #(
	parameter int unsigned RING_LEDS = lrg_pkg::RING_LEDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lrg_pkg::cfg_t                 cfg,
	input  logic                          q_valid,
	input  lrg_pkg::item_t                q_item,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// Fields from bit 0: pixel_index[3:0], red[11:4], green[19:12], blue[27:20], zero fill.
	output logic [lrg_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                          m_tlast
);

	localparam int unsigned IW      = lrg_pkg::IDX_W;
	localparam int unsigned CW      = lrg_pkg::CH_W;
	localparam int unsigned RECIP_S = 20;
	localparam logic [RECIP_S-1:0] RECIP = RECIP_S'((2 ** RECIP_S) / RING_LEDS);

	// Pipeline advances whenever the output register can take a new pixel.
	logic en;
	assign en = !m_tvalid || m_tready;

	// ---------------- Sequencer ----------------
	logic                         busy_q;
	logic [IW-1:0]                idx_q;
	logic [IW-1:0]                k_q;
	logic [lrg_pkg::ANGLE_W-1:0]  angle_q;
	logic                         seq_last;

	assign seq_last = (k_q == IW'(RING_LEDS - 1));
	assign q_pop    = q_valid && (!busy_q || (en && seq_last));

	// Load the next item as the current run issues its last pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			k_q    <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= q_item.start_idx;
			k_q    <= '0;
		end else if (en && busy_q) begin
			if (seq_last) begin
				busy_q <= 1'b0;
			end else begin
				k_q   <= k_q + 1'b1;
				idx_q <= (idx_q == IW'(RING_LEDS - 1)) ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			angle_q <= q_item.angle;
		end
	end

	// ---------------- Pipeline registers ----------------
	logic          vld_s  [2:12];
	logic [IW-1:0] idx_s  [2:12];
	logic          last_s [2:12];
	logic [CW-1:0] col_s  [4:12][3];

	logic [17:0] half_s2;
	logic [13:0] num_s2 [3];
	logic [37:0] hprod_s3;
	logic [17:0] half_s3;
	logic [33:0] nprod_s3 [3];
	logic [13:0] num_s3 [3];
	logic [12:0] u_s4;
	logic        neg_s5, neg_s6, neg_s7, neg_s8;
	logic [11:0] uf_s5;
	logic [4:0]  seg_s6;
	logic [7:0]  frac_s6;
	logic [15:0] lo_s7, lo_s8;
	logic        sat_s7, sat_s8;
	logic [19:0] p_s7;
	logic [29:0] yq_s8;
	logic [16:0] w_s9;
	logic signed [27:0] t_s10;
	logic [CW-1:0] b_s11;
	logic [15:0] prod_s12 [3];

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int st = 2; st <= 12; st++) begin
				vld_s[st] <= 1'b0;
			end
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_s[2] <= busy_q;
			for (int st = 3; st <= 12; st++) begin
				vld_s[st] <= vld_s[st-1];
			end
			m_tvalid <= vld_s[12];
		end
	end

	// Stage 2: half angle difference scaled by the ring size, color blend numerators.
	logic [17:0] a_x, c_x;
	logic [5:0]  rem_x;
	always_comb begin
		a_x   = 18'(angle_q) * 18'(RING_LEDS);
		c_x   = 18'({idx_q, 1'b1}) * 18'(2880);
		rem_x = 6'(RING_LEDS) - 6'(idx_q);
	end

	// Stage 4 quotient corrections by the ring size.
	logic [17:0] hq_x, hr_x;
	logic [13:0] nq_x [3];
	logic [13:0] nr_x [3];
	logic [CW-1:0] c4_x [3];
	always_comb begin
		hq_x = hprod_s3[37:RECIP_S];
		hr_x = half_s3 - 18'(hq_x * 18'(RING_LEDS));
		for (int ch = 0; ch < 3; ch++) begin
			nq_x[ch] = nprod_s3[ch][33:RECIP_S];
			nr_x[ch] = num_s3[ch] - 14'(nq_x[ch] * 14'(RING_LEDS));
			if (cfg.mode == lrg_pkg::MODE_GRADIENT) begin
				c4_x[ch] = CW'((nr_x[ch] >= 14'(RING_LEDS)) ? nq_x[ch] + 1'b1 : nq_x[ch]);
			end else begin
				c4_x[ch] = lrg_pkg::color_chan(cfg.start_color, ch);
			end
		end
	end

	// Stage 5 fold into the first quadrant.
	logic        neg_x;
	logic [12:0] v_x;
	always_comb begin
		neg_x = (u_s4 >= 13'd5760);
		v_x   = neg_x ? u_s4 - 13'd5760 : u_s4;
	end

	// Stage 6 segment and fraction: seg = uf / 160 by (uf/32) * 205 / 1024.
	logic [14:0] segp_x;
	logic [4:0]  seg_x;
	always_comb begin
		segp_x = 15'(uf_s5[11:5]) * 15'(205);
		seg_x  = segp_x[14:10];
	end

	// Stage 9 sine magnitude and its complement.
	logic [15:0] mag_x;
	always_comb begin
		mag_x = sat_s8 ? 16'd32768 : lo_s8 + 16'(yq_s8[29:18]);
	end

	// Stage 10 brightness numerator.
	logic signed [27:0] base_x, diff_x, wv_x;
	always_comb begin
		base_x = $signed({5'b0, cfg.floor_brightness, 15'b0});
		diff_x = $signed(28'(cfg.peak_brightness)) - $signed(28'(cfg.floor_brightness));
		wv_x   = $signed(28'(w_s9));
	end

	// Output division by 255, exact for 16-bit products.
	logic [16:0] div_x [3];
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			div_x[ch] = 17'(prod_s12[ch]) + 17'd1 + 17'(prod_s12[ch][15:8]);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 2.
			idx_s[2]  <= idx_q;
			last_s[2] <= seq_last;
			half_s2   <= (a_x >= c_x) ? a_x - c_x : c_x - a_x;
			for (int ch = 0; ch < 3; ch++) begin
				num_s2[ch] <= 14'(lrg_pkg::color_chan(cfg.start_color, ch)) * 14'(rem_x) +
				              14'(lrg_pkg::color_chan(cfg.end_color, ch)) * 14'(idx_q);
			end
			// Stage 3: reciprocal products.
			hprod_s3 <= 38'(half_s2) * 38'(RECIP);
			half_s3  <= half_s2;
			for (int ch = 0; ch < 3; ch++) begin
				nprod_s3[ch] <= 34'(num_s2[ch]) * 34'(RECIP);
				num_s3[ch]   <= num_s2[ch];
			end
			// Stage 4: corrected quotients.
			u_s4 <= 13'((hr_x >= 18'(RING_LEDS)) ? hq_x + 1'b1 : hq_x);
			for (int ch = 0; ch < 3; ch++) begin
				col_s[4][ch] <= c4_x[ch];
			end
			// Stage 5.
			neg_s5 <= neg_x;
			uf_s5  <= 12'((v_x > 13'd2880) ? 13'd5760 - v_x : v_x);
			// Stage 6.
			neg_s6  <= neg_s5;
			seg_s6  <= seg_x;
			frac_s6 <= 8'(uf_s5 - 12'(seg_x) * 12'd160);
			// Stage 7: table lookup and interpolation product.
			neg_s7 <= neg_s6;
			sat_s7 <= (seg_s6 >= 5'd18);
			lo_s7  <= lrg_pkg::sine_q15(seg_s6);
			p_s7   <= 20'(lrg_pkg::sine_q15(seg_s6 + 1'b1) - lrg_pkg::sine_q15(seg_s6)) *
			          20'(frac_s6);
			// Stage 8: divide by 160 as /32 then by 5 through 52429 / 2^18.
			neg_s8 <= neg_s7;
			sat_s8 <= sat_s7;
			lo_s8  <= lo_s7;
			yq_s8  <= 30'(p_s7[19:5]) * 30'(52429);
			// Stage 9: one minus the signed sine, in Q2.15.
			w_s9 <= neg_s8 ? 17'd32768 + 17'(mag_x) : 17'd32768 - 17'(mag_x);
			// Stage 10.
			t_s10 <= base_x + diff_x * wv_x;
			// Stage 11: clamp to 0..255.
			if (t_s10 < 0) begin
				b_s11 <= '0;
			end else if (t_s10[27:15] > 13'd255) begin
				b_s11 <= 8'd255;
			end else begin
				b_s11 <= t_s10[22:15];
			end
			// Stage 12: scale the color.
			for (int ch = 0; ch < 3; ch++) begin
				prod_s12[ch] <= 16'(col_s[11][ch]) * 16'(b_s11);
			end
			// Carried tags and colors.
			for (int st = 3; st <= 12; st++) begin
				idx_s[st]  <= idx_s[st-1];
				last_s[st] <= last_s[st-1];
			end
			for (int st = 5; st <= 12; st++) begin
				col_s[st] <= col_s[st-1];
			end
			// Output register.
			m_tdata <= {4'b0, div_x[2][15:8], div_x[1][15:8], div_x[0][15:8],
			            idx_s[12][lrg_pkg::CIDX_W-1:0]};
			m_tlast <= last_s[12];
		end
	end

endmodule
